>>> src/stcp_pkg.sv
// Shared types, constants and helper functions for the sample to colour pixel block.
// Used by the top level, the pipelined divider and the port checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package stcp_pkg;

	localparam int unsigned SAMPLE_W   = 32;
	localparam int unsigned LEVEL_W    = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// level divider: (v - lo) * 255 over (hi - lo)
	localparam int unsigned LVL_NUM_W = SAMPLE_W + LEVEL_W;
	localparam int unsigned LVL_DEN_W = SAMPLE_W;

	// hot ramp divider: (level - base) * 255 over span
	localparam int unsigned HOT_NUM_W = 2 * LEVEL_W;
	localparam int unsigned HOT_DEN_W = LEVEL_W + 1;

	// register stages from the input register to the output register inclusive
	localparam int unsigned PIPE_DEPTH = 2 * LEVEL_W + 5;

	localparam logic [7:0] LVL_FULL = 8'd255;

	localparam logic [7:0] JET_OFS_RED   = 8'd96;
	localparam logic [7:0] JET_OFS_GREEN = 8'd32;
	localparam logic [7:0] JET_OFS_BLUE  = 8'd224;
	localparam logic [7:0] JET_RED_FROM  = 8'd64;
	localparam logic [7:0] JET_BLUE_TO   = 8'd192;

	localparam logic signed [31:0] RST_SCALE_LOW  = 32'sd0;
	localparam logic signed [31:0] RST_SCALE_HIGH = 32'sd65280;
	localparam logic [7:0]         RST_TINT_RED   = 8'd0;
	localparam logic [7:0]         RST_TINT_GREEN = 8'd255;
	localparam logic [7:0]         RST_TINT_BLUE  = 8'd0;
	localparam logic [7:0]         RST_HOT_SPAN   = 8'd96;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE_LOW  = 3'd0,
		CFG_SCALE_HIGH = 3'd1,
		CFG_MAP_MODE   = 3'd2,
		CFG_TINT_RED   = 3'd3,
		CFG_TINT_GREEN = 3'd4,
		CFG_TINT_BLUE  = 3'd5,
		CFG_HOT_RED    = 3'd6,
		CFG_HOT_GREEN  = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MAP_GREY = 2'd0,
		MAP_TINT = 2'd1,
		MAP_HOT  = 2'd2,
		MAP_JET  = 2'd3
	} map_mode_t;

	typedef enum logic [1:0] {
		SEG_RED   = 2'd0,
		SEG_GREEN = 2'd1,
		SEG_BLUE  = 2'd2
	} hot_seg_t;

	// clamp flags carried alongside the level division
	typedef struct packed {
		logic lo_hit;
		logic hi_hit;
	} lvl_side_t;

	// colour context carried alongside the hot ramp division
	typedef struct packed {
		logic [7:0] level;
		logic [7:0] pre_r;
		logic [7:0] pre_g;
		logic [7:0] pre_b;
		hot_seg_t   seg;
	} hot_side_t;

	// floor(x / 255) for x up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

	// one channel of the jet map, before the red and blue end cuts
	function automatic logic [7:0] jet_channel(input logic [7:0] lvl, input logic [7:0] ofs);
		logic [7:0] d;
		logic [7:0] dm;
		logic [7:0] res;
		d  = lvl - ofs;
		dm = d - 8'd127;
		case (d) inside
			[8'd0:8'd62]:    res = {d[5:0] + 6'd1, 2'b00};
			[8'd63:8'd127]:  res = 8'd255;
			[8'd128:8'd190]: res = 8'd255 - {dm[5:0], 2'b00};
			default:         res = 8'd0;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

>>> src/stcp_div.sv
// Pipelined restoring divider: one quotient bit per register stage, sideband carried along.
// Depends on stcp_pkg for default widths. Quotient must fit QUO_W bits (num < den << QUO_W).
`timescale 1ns / 1ps
`default_nettype none

module stcp_div #(
	parameter int unsigned NUM_W  = stcp_pkg::LVL_NUM_W,
	parameter int unsigned DEN_W  = stcp_pkg::LVL_DEN_W,
	parameter int unsigned QUO_W  = stcp_pkg::LEVEL_W,
	parameter int unsigned SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_vld,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_vld,
	output logic [QUO_W-1:0]       quo,
	output logic [SIDE_W-1:0]      side_out
);

	localparam int unsigned CMP_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

	logic [QUO_W-1:0]  vld_s;
	logic [NUM_W-1:0]  rem_s  [QUO_W];
	logic [DEN_W-1:0]  den_s  [QUO_W];
	logic [QUO_W-1:0]  quo_s  [QUO_W];
	logic [SIDE_W-1:0] side_s [QUO_W];

	logic [NUM_W-1:0]  rem_in  [QUO_W];
	logic [DEN_W-1:0]  den_in  [QUO_W];
	logic [QUO_W-1:0]  quo_in  [QUO_W];
	logic [SIDE_W-1:0] side_a  [QUO_W];
	logic [NUM_W-1:0]  rem_nxt [QUO_W];
	logic [QUO_W-1:0]  quo_nxt [QUO_W];

	// stage i decides quotient bit QUO_W-1-i
	always_comb begin
		logic [CMP_W-1:0] trial;
		for (int i = 0; i < QUO_W; i++) begin
			if (i == 0) begin
				rem_in[i] = num;
				den_in[i] = den;
				quo_in[i] = '0;
				side_a[i] = side_in;
			end else begin
				rem_in[i] = rem_s[i-1];
				den_in[i] = den_s[i-1];
				quo_in[i] = quo_s[i-1];
				side_a[i] = side_s[i-1];
			end
			trial = CMP_W'(rem_in[i]) - (CMP_W'(den_in[i]) << (QUO_W - 1 - i));
			rem_nxt[i] = trial[CMP_W-1] ? rem_in[i] : trial[NUM_W-1:0];
			quo_nxt[i] = {quo_in[i][QUO_W-2:0], ~trial[CMP_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QUO_W-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < QUO_W; i++) begin
				rem_s[i]  <= rem_nxt[i];
				den_s[i]  <= den_in[i];
				quo_s[i]  <= quo_nxt[i];
				side_s[i] <= side_a[i];
			end
		end
	end

	assign out_vld  = vld_s[QUO_W-1];
	assign quo      = quo_s[QUO_W-1];
	assign side_out = side_s[QUO_W-1];

endmodule

`default_nettype wire

>>> src/sample_to_colour_pixel.sv
// Top level: clamped linear scale of a Q24.8 sample to an 8-bit level, then a colour map.
// Depends on stcp_pkg and stcp_div (two instances: level division and hot ramp division).
//
// Usage
//   Input channel  : sample_valid / sample_ready, payload sample (signed Q24.8).
//   Output channel : pixel_valid / pixel_ready, payload level, red, green, blue.
//   Config port    : wr_en, wr_idx, wr_data; a register is written on any edge with wr_en high.
//                    Write only while no item is in flight.
//   Throughput     : one item per clock while pixel_ready is high.
//   Depth          : 21 register stages, set by the two 8-stage restoring dividers (one
//                    quotient bit per stage), plus the front, colour and output stages.
//   Stall          : the whole pipeline holds while a pixel waits and pixel_ready is low;
//                    empty stages hold too, so sample_ready is low whenever a stalled pixel waits.
//   Reset          : arst_n clears all valid bits and loads the default registers
//                    (scale 0 to 255.0, constant green tint, hot spans of 96).
//   Reversed or equal scale bounds give 0 at or below scale_low and 255 above it.
`timescale 1ns / 1ps
`default_nettype none

module sample_to_colour_pixel (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                sample_valid,
	output logic                                     sample_ready,
	input  wire logic signed [stcp_pkg::SAMPLE_W-1:0] sample,
	output logic                                     pixel_valid,
	input  wire logic                                pixel_ready,
	output logic [stcp_pkg::LEVEL_W-1:0]             level,
	output logic [stcp_pkg::LEVEL_W-1:0]             red,
	output logic [stcp_pkg::LEVEL_W-1:0]             green,
	output logic [stcp_pkg::LEVEL_W-1:0]             blue,
	input  wire logic                                wr_en,
	input  wire logic [stcp_pkg::CFG_IDX_W-1:0]      wr_idx,
	input  wire logic [stcp_pkg::CFG_DATA_W-1:0]     wr_data
);

	localparam int unsigned HOT_SIDE_W = $bits(stcp_pkg::hot_side_t);
	localparam int unsigned LVL_SIDE_W = $bits(stcp_pkg::lvl_side_t);

	// ---------------------------------------------------------------- config
	logic signed [31:0]  scale_low_q;
	logic signed [31:0]  scale_high_q;
	stcp_pkg::map_mode_t map_mode_q;
	logic [7:0]          tint_red_q;
	logic [7:0]          tint_green_q;
	logic [7:0]          tint_blue_q;
	logic [7:0]          hot_red_q;
	logic [7:0]          hot_green_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_low_q  <= stcp_pkg::RST_SCALE_LOW;
			scale_high_q <= stcp_pkg::RST_SCALE_HIGH;
			map_mode_q   <= stcp_pkg::MAP_TINT;
			tint_red_q   <= stcp_pkg::RST_TINT_RED;
			tint_green_q <= stcp_pkg::RST_TINT_GREEN;
			tint_blue_q  <= stcp_pkg::RST_TINT_BLUE;
			hot_red_q    <= stcp_pkg::RST_HOT_SPAN;
			hot_green_q  <= stcp_pkg::RST_HOT_SPAN;
		end else if (wr_en) begin
			case (stcp_pkg::cfg_idx_t'(wr_idx))
				stcp_pkg::CFG_SCALE_LOW:  scale_low_q  <= wr_data;
				stcp_pkg::CFG_SCALE_HIGH: scale_high_q <= wr_data;
				stcp_pkg::CFG_MAP_MODE:   map_mode_q   <= stcp_pkg::map_mode_t'(wr_data[1:0]);
				stcp_pkg::CFG_TINT_RED:   tint_red_q   <= wr_data[7:0];
				stcp_pkg::CFG_TINT_GREEN: tint_green_q <= wr_data[7:0];
				stcp_pkg::CFG_TINT_BLUE:  tint_blue_q  <= wr_data[7:0];
				stcp_pkg::CFG_HOT_RED:    hot_red_q    <= wr_data[7:0];
				stcp_pkg::CFG_HOT_GREEN:  hot_green_q  <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ flow control
	// One enable for every stage: advance unless a pixel sits unaccepted at the output.
	logic adv;
	logic pixel_valid_q;

	assign adv          = ~pixel_valid_q | pixel_ready;
	assign sample_ready = adv;

	// ----------------------------------------------- stage 1: clamp and offsets
	logic        vld_s1;
	logic        lo_hit_s1;
	logic        hi_hit_s1;
	logic [31:0] diff_s1;
	logic [31:0] den_s1;

	// Low-order 32 bits of both differences are exact whenever the division is used
	// (scale_low < sample < scale_high).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_hit_s1 <= (sample <= scale_low_q);
			hi_hit_s1 <= (sample >= scale_high_q);
			diff_s1   <= 32'(sample - scale_low_q);
			den_s1    <= 32'(scale_high_q - scale_low_q);
		end
	end

	// ------------------------------------------ stage 2: numerator times 255
	logic                                 vld_s2;
	stcp_pkg::lvl_side_t                  side_s2;
	logic [stcp_pkg::LVL_NUM_W-1:0]       num_s2;
	logic [31:0]                          den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2.lo_hit <= lo_hit_s1;
			side_s2.hi_hit <= hi_hit_s1;
			num_s2         <= {diff_s1, 8'd0} - {8'd0, diff_s1};
			den_s2         <= den_s1;
		end
	end

	// ------------------------------------------- stages 3..10: level division
	logic                      lvl_vld;
	logic [7:0]                lvl_quo;
	logic [LVL_SIDE_W-1:0]     lvl_side_raw;
	stcp_pkg::lvl_side_t       lvl_side;

	stcp_div #(
		.NUM_W  (stcp_pkg::LVL_NUM_W),
		.DEN_W  (stcp_pkg::LVL_DEN_W),
		.QUO_W  (stcp_pkg::LEVEL_W),
		.SIDE_W (LVL_SIDE_W)
	) u_lvl_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s2),
		.num      (num_s2),
		.den      (den_s2),
		.side_in  (side_s2),
		.out_vld  (lvl_vld),
		.quo      (lvl_quo),
		.side_out (lvl_side_raw)
	);

	assign lvl_side = stcp_pkg::lvl_side_t'(lvl_side_raw);

	// ------------------------------- stage c1: level, tint products, jet, hot segment
	logic [7:0] lvl_c;
	logic [8:0] hot_rg_sum;
	logic [9:0] hot_blue_den;

	always_comb begin
		if (lvl_side.lo_hit) begin
			lvl_c = 8'd0;
		end else if (lvl_side.hi_hit) begin
			lvl_c = stcp_pkg::LVL_FULL;
		end else begin
			lvl_c = lvl_quo;
		end
	end

	assign hot_rg_sum   = 9'(hot_red_q) + 9'(hot_green_q);
	assign hot_blue_den = 10'd256 - 10'(hot_rg_sum);

	logic               vld_c1;
	logic [7:0]         level_c1;
	logic [15:0]        prod_r_c1;
	logic [15:0]        prod_g_c1;
	logic [15:0]        prod_b_c1;
	logic [7:0]         jet_r_c1;
	logic [7:0]         jet_g_c1;
	logic [7:0]         jet_b_c1;
	stcp_pkg::hot_seg_t seg_c1;
	logic [7:0]         hot_base_c1;
	logic [8:0]         hot_den_c1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c1 <= 1'b0;
		end else if (adv) begin
			vld_c1 <= lvl_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_c1  <= lvl_c;
			prod_r_c1 <= 16'(lvl_c) * 16'(tint_red_q);
			prod_g_c1 <= 16'(lvl_c) * 16'(tint_green_q);
			prod_b_c1 <= 16'(lvl_c) * 16'(tint_blue_q);
			// jet: red off in the lowest quarter, blue off in the top quarter
			jet_r_c1  <= (lvl_c < stcp_pkg::JET_RED_FROM) ? 8'd0 :
			             stcp_pkg::jet_channel(lvl_c, stcp_pkg::JET_OFS_RED);
			jet_g_c1  <= stcp_pkg::jet_channel(lvl_c, stcp_pkg::JET_OFS_GREEN);
			jet_b_c1  <= (lvl_c >= stcp_pkg::JET_BLUE_TO) ? 8'd0 :
			             stcp_pkg::jet_channel(lvl_c, stcp_pkg::JET_OFS_BLUE);
			// hot: pick the ramp this level sits on; an empty span is never chosen
			if (lvl_c < hot_red_q) begin
				seg_c1      <= stcp_pkg::SEG_RED;
				hot_base_c1 <= lvl_c;
				hot_den_c1  <= 9'(hot_red_q);
			end else if (9'(lvl_c) < hot_rg_sum) begin
				seg_c1      <= stcp_pkg::SEG_GREEN;
				hot_base_c1 <= lvl_c - hot_red_q;
				hot_den_c1  <= 9'(hot_green_q);
			end else begin
				seg_c1      <= stcp_pkg::SEG_BLUE;
				hot_base_c1 <= 8'(9'(lvl_c) - hot_rg_sum);
				hot_den_c1  <= hot_blue_den[8:0];
			end
		end
	end

	// -------------------------------- stage c2: pre-colour and hot numerator
	logic [7:0] pre_r;
	logic [7:0] pre_g;
	logic [7:0] pre_b;

	always_comb begin
		case (map_mode_q)
			stcp_pkg::MAP_GREY: begin
				pre_r = level_c1;
				pre_g = level_c1;
				pre_b = level_c1;
			end
			stcp_pkg::MAP_TINT: begin
				pre_r = stcp_pkg::div255(prod_r_c1);
				pre_g = stcp_pkg::div255(prod_g_c1);
				pre_b = stcp_pkg::div255(prod_b_c1);
			end
			stcp_pkg::MAP_JET: begin
				pre_r = jet_r_c1;
				pre_g = jet_g_c1;
				pre_b = jet_b_c1;
			end
			default: begin
				// hot map: filled in after the ramp division
				pre_r = 8'd0;
				pre_g = 8'd0;
				pre_b = 8'd0;
			end
		endcase
	end

	logic                           vld_c2;
	stcp_pkg::hot_side_t            side_c2;
	logic [stcp_pkg::HOT_NUM_W-1:0] hot_num_c2;
	logic [stcp_pkg::HOT_DEN_W-1:0] hot_den_c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c2 <= 1'b0;
		end else if (adv) begin
			vld_c2 <= vld_c1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_c2.level <= level_c1;
			side_c2.pre_r <= pre_r;
			side_c2.pre_g <= pre_g;
			side_c2.pre_b <= pre_b;
			side_c2.seg   <= seg_c1;
			hot_num_c2    <= {hot_base_c1, 8'd0} - {8'd0, hot_base_c1};
			hot_den_c2    <= hot_den_c1;
		end
	end

	// --------------------------------------- hot ramp division, 8 stages
	logic                  hot_vld;
	logic [7:0]            hot_quo;
	logic [HOT_SIDE_W-1:0] hot_side_raw;
	stcp_pkg::hot_side_t   hot_side;

	stcp_div #(
		.NUM_W  (stcp_pkg::HOT_NUM_W),
		.DEN_W  (stcp_pkg::HOT_DEN_W),
		.QUO_W  (stcp_pkg::LEVEL_W),
		.SIDE_W (HOT_SIDE_W)
	) u_hot_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_c2),
		.num      (hot_num_c2),
		.den      (hot_den_c2),
		.side_in  (side_c2),
		.out_vld  (hot_vld),
		.quo      (hot_quo),
		.side_out (hot_side_raw)
	);

	assign hot_side = stcp_pkg::hot_side_t'(hot_side_raw);

	// -------------------------------------------------- output register
	logic [7:0] fin_r;
	logic [7:0] fin_g;
	logic [7:0] fin_b;

	always_comb begin
		fin_r = hot_side.pre_r;
		fin_g = hot_side.pre_g;
		fin_b = hot_side.pre_b;
		if (map_mode_q == stcp_pkg::MAP_HOT) begin
			case (hot_side.seg)
				stcp_pkg::SEG_RED: begin
					fin_r = hot_quo;
					fin_g = 8'd0;
					fin_b = 8'd0;
				end
				stcp_pkg::SEG_GREEN: begin
					fin_r = stcp_pkg::LVL_FULL;
					fin_g = hot_quo;
					fin_b = 8'd0;
				end
				stcp_pkg::SEG_BLUE: begin
					fin_r = stcp_pkg::LVL_FULL;
					fin_g = stcp_pkg::LVL_FULL;
					fin_b = hot_quo;
				end
				default: ;
			endcase
		end
	end

	logic [7:0] level_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid_q <= 1'b0;
		end else if (adv) begin
			pixel_valid_q <= hot_vld;
		end
	end

	// hold the pixel while the receiver stalls
	always_ff @(posedge clk) begin
		if (adv) begin
			level_q <= hot_side.level;
			red_q   <= fin_r;
			green_q <= fin_g;
			blue_q  <= fin_b;
		end
	end

	assign pixel_valid = pixel_valid_q;
	assign level       = level_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;

endmodule

`default_nettype wire

>>> src/stcp_checker.sv
// Port-level checker for sample_to_colour_pixel, bound to the top level.
// Depends on stcp_pkg for the pipeline depth; watches the handshake and pixel ports only.
`timescale 1ns / 1ps
`default_nettype none

module stcp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       sample_valid,
	input wire logic       sample_ready,
	input wire logic       pixel_valid,
	input wire logic       pixel_ready,
	input wire logic [7:0] level,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue
);

	localparam int unsigned CNT_W = $clog2(stcp_pkg::PIPE_DEPTH + 1);

	logic [CNT_W-1:0] inflight_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = sample_valid & sample_ready;
	assign out_acc = pixel_valid & pixel_ready;

	// items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(in_acc) - CNT_W'(out_acc);
		end
	end

	a_no_phantom_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> inflight_q != '0)
		else $error("pixel shown with no item in flight");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(stcp_pkg::PIPE_DEPTH))
		else $error("more items in flight than pipeline stages");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!pixel_valid || pixel_ready) |-> sample_ready)
		else $error("input stalled while the output can move");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_ready |=> pixel_valid && $stable(level) && $stable(red)
			&& $stable(green) && $stable(blue))
		else $error("stalled pixel changed or dropped");

endmodule

bind sample_to_colour_pixel stcp_checker u_stcp_checker (.*);

`default_nettype wire

>>> bench/sample_to_colour_pixel_tb.sv
// Self-checking bench for sample_to_colour_pixel: scale, clamp and colour map of Q24.8 samples.
// Needs stcp_pkg and the block's RTL; prediction is worked out here, independent of the RTL.
`timescale 1ns / 1ps

module sample_to_colour_pixel_tb;

	// cycles with no item moving on either side before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	// cycles to let the pipeline empty before a register write or the end of the run
	localparam int SETTLE_CYCLES = stcp_pkg::PIPE_DEPTH + 4;
	localparam int RANDOM_PHASES = 16;
	localparam int ITEMS_PER_PHASE = 50;

	// jet channel start offsets and the end cuts on red and blue
	localparam int unsigned JET_START_RED   = 96;
	localparam int unsigned JET_START_GREEN = 32;
	localparam int unsigned JET_START_BLUE  = 224;
	localparam int unsigned JET_RED_CUT     = 64;
	localparam int unsigned JET_BLUE_CUT    = 192;

	typedef struct {
		logic signed [31:0]  lo;
		logic signed [31:0]  hi;
		stcp_pkg::map_mode_t mode;
		logic [7:0]          tint_r;
		logic [7:0]          tint_g;
		logic [7:0]          tint_b;
		logic [7:0]          hot_red;
		logic [7:0]          hot_green;
	} colour_setup_t;

	typedef struct packed {
		logic [7:0] level;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// Holds a copy of the registers, predicts each pixel and keeps the pixels still owed.
	class pixel_scoreboard;
		colour_setup_t setup;
		pixel_t        owed_q[$];
		int            errors;

		function new();
			setup = '{stcp_pkg::RST_SCALE_LOW, stcp_pkg::RST_SCALE_HIGH, stcp_pkg::MAP_TINT,
				stcp_pkg::RST_TINT_RED, stcp_pkg::RST_TINT_GREEN, stcp_pkg::RST_TINT_BLUE,
				stcp_pkg::RST_HOT_SPAN, stcp_pkg::RST_HOT_SPAN};
			errors = 0;
		endfunction

		// mirror a register write; narrow registers keep only their low bits
		function void set_reg(stcp_pkg::cfg_idx_t idx, logic [31:0] data);
			case (idx)
				stcp_pkg::CFG_SCALE_LOW:  setup.lo = data;
				stcp_pkg::CFG_SCALE_HIGH: setup.hi = data;
				stcp_pkg::CFG_MAP_MODE:   setup.mode = stcp_pkg::map_mode_t'(data[1:0]);
				stcp_pkg::CFG_TINT_RED:   setup.tint_r = data[7:0];
				stcp_pkg::CFG_TINT_GREEN: setup.tint_g = data[7:0];
				stcp_pkg::CFG_TINT_BLUE:  setup.tint_b = data[7:0];
				stcp_pkg::CFG_HOT_RED:    setup.hot_red = data[7:0];
				stcp_pkg::CFG_HOT_GREEN:  setup.hot_green = data[7:0];
				default: ;
			endcase
		endfunction

		function int unsigned jet_ramp(int unsigned lv, int unsigned start);
			int unsigned d;
			d = (lv - start) & 255;
			if (d < 63)
				return 4 * (d + 1);
			if (d < 128)
				return 255;
			if (d < 191)
				return 255 - 4 * (d - 127);
			return 0;
		endfunction

		function pixel_t colour_of(logic signed [31:0] s);
			longint v, lo, hi;
			int unsigned lv, rs, gs, r, g, b;
			pixel_t p;
			v  = s;
			lo = setup.lo;
			hi = setup.hi;
			// reversed or equal bounds never reach the division
			if (v <= lo)
				lv = 0;
			else if (v >= hi)
				lv = 255;
			else
				lv = 32'(((v - lo) * 255) / (hi - lo));
			rs = setup.hot_red;
			gs = setup.hot_green;
			case (setup.mode)
				stcp_pkg::MAP_GREY: begin
					r = lv;
					g = lv;
					b = lv;
				end
				stcp_pkg::MAP_TINT: begin
					r = lv * setup.tint_r / 255;
					g = lv * setup.tint_g / 255;
					b = lv * setup.tint_b / 255;
				end
				stcp_pkg::MAP_HOT: begin
					// a zero span leaves its ramp empty; spans past 255 never reach blue
					if (lv < rs) begin
						r = lv * 255 / rs;
						g = 0;
						b = 0;
					end else if (lv < rs + gs) begin
						r = 255;
						g = (lv - rs) * 255 / gs;
						b = 0;
					end else begin
						r = 255;
						g = 255;
						b = (lv - rs - gs) * 255 / (256 - rs - gs);
					end
				end
				default: begin
					r = jet_ramp(lv, JET_START_RED);
					g = jet_ramp(lv, JET_START_GREEN);
					b = jet_ramp(lv, JET_START_BLUE);
					if (lv < JET_RED_CUT)
						r = 0;
					if (lv >= JET_BLUE_CUT)
						b = 0;
				end
			endcase
			p.level = lv[7:0];
			p.red   = r[7:0];
			p.green = g[7:0];
			p.blue  = b[7:0];
			return p;
		endfunction

		function void note_sample(logic signed [31:0] s);
			owed_q = {owed_q, colour_of(s)};
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (owed_q.size() == 0) begin
				errors++;
				$display("%0t: pixel with no item pending, expected none, got %h",
					$time, got);
				return;
			end
			want = owed_q.pop_front();
			compare_field("level", want.level, got.level);
			compare_field("red", want.red, got.red);
			compare_field("green", want.green, got.green);
			compare_field("blue", want.blue, got.blue);
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               sample_valid;
	logic               sample_ready;
	logic signed [31:0] sample;
	logic               pixel_valid;
	logic               pixel_ready;
	logic [7:0]         level;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic               wr_en;
	logic [2:0]         wr_idx;
	logic [31:0]        wr_data;

	// set for a stretch of phases in which neither side idles
	logic               steady;
	int                 stall_cycles;
	pixel_scoreboard    sb;

	sample_to_colour_pixel uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.level        (level),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.wr_en        (wr_en),
		.wr_idx       (wr_idx),
		.wr_data      (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Pixel side: check every accepted pixel, then choose whether to stall next cycle.
	always @(posedge clk) begin
		if (pixel_valid === 1'b1 && pixel_ready === 1'b1)
			sb.check_pixel(pixel_t'{level, red, green, blue});
		pixel_ready <= steady || ($urandom_range(0, 99) >= 9);
	end

	// Watchdog: give up once nothing has moved on either side for too long.
	always @(posedge clk) begin
		if ((sample_valid && sample_ready === 1'b1) || (pixel_valid === 1'b1 && pixel_ready))
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	// Offer one sample and hold it until taken. Valid stays high on return so that
	// back-to-back items need no drop; a gap lowers it before the next item.
	task automatic send_sample(input logic signed [31:0] s);
		while (!steady && $urandom_range(0, 99) < 9) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		@(posedge clk);
		while (sample_ready !== 1'b1)
			@(posedge clk);
		sb.note_sample(s);
	endtask

	// Drop valid, wait for every owed pixel, then let the pipeline run empty.
	task automatic wait_for_idle();
		sample_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input stcp_pkg::cfg_idx_t idx, input logic [31:0] data);
		wr_en   <= 1'b1;
		wr_idx  <= idx;
		wr_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// Load all eight registers once the block is idle; narrow registers get junk
	// in their unused upper bits, which the block must drop.
	task automatic apply_setup(input colour_setup_t c);
		wait_for_idle();
		write_reg(stcp_pkg::CFG_SCALE_LOW, c.lo);
		write_reg(stcp_pkg::CFG_SCALE_HIGH, c.hi);
		write_reg(stcp_pkg::CFG_MAP_MODE, ($urandom & 32'hFFFF_FFFC) | 32'(c.mode));
		write_reg(stcp_pkg::CFG_TINT_RED, ($urandom & 32'hFFFF_FF00) | 32'(c.tint_r));
		write_reg(stcp_pkg::CFG_TINT_GREEN, ($urandom & 32'hFFFF_FF00) | 32'(c.tint_g));
		write_reg(stcp_pkg::CFG_TINT_BLUE, ($urandom & 32'hFFFF_FF00) | 32'(c.tint_b));
		write_reg(stcp_pkg::CFG_HOT_RED, ($urandom & 32'hFFFF_FF00) | 32'(c.hot_red));
		write_reg(stcp_pkg::CFG_HOT_GREEN, ($urandom & 32'hFFFF_FF00) | 32'(c.hot_green));
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// favour the ends of the byte range
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 4))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// a random value of random magnitude, so that narrow and wide ranges both occur
	function automatic logic signed [31:0] pick_bound();
		logic signed [31:0] x;
		x = $urandom;
		return x >>> $urandom_range(0, 31);
	endfunction

	function automatic colour_setup_t random_setup();
		colour_setup_t c;
		logic signed [31:0] a, b;
		a = pick_bound();
		b = pick_bound();
		case ($urandom_range(0, 9))
			0: begin
				c.lo = stcp_pkg::RST_SCALE_LOW;
				c.hi = stcp_pkg::RST_SCALE_HIGH;
			end
			1: begin
				c.lo = 32'sh8000_0000;
				c.hi = 32'sh7FFF_FFFF;
			end
			2: begin
				// reversed bounds
				c.lo = (a > b) ? a : b;
				c.hi = (a > b) ? b : a;
			end
			3: begin
				c.lo = a;
				c.hi = a;
			end
			default: begin
				c.lo = (a < b) ? a : b;
				c.hi = (a < b) ? b : a;
			end
		endcase
		c.mode      = stcp_pkg::map_mode_t'($urandom_range(0, 3));
		c.tint_r    = pick_byte();
		c.tint_g    = pick_byte();
		c.tint_b    = pick_byte();
		c.hot_red   = pick_byte();
		c.hot_green = pick_byte();
		return c;
	endfunction

	// Most samples land between the bounds so the levels spread; the rest hit the
	// bounds, their neighbours, the extremes of the field, or anywhere at all.
	function automatic logic signed [31:0] random_sample(input colour_setup_t c);
		longint lo, hi;
		longint unsigned span;
		lo = (c.lo < c.hi) ? c.lo : c.hi;
		hi = (c.lo < c.hi) ? c.hi : c.lo;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 5))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return c.lo;
					3: return c.hi;
					4: return c.lo + 32'sd1;
					default: return c.hi - 32'sd1;
				endcase
			end
			default: begin
				span = longint'(hi - lo) + 1;
				return 32'(lo + longint'({$urandom, $urandom} % span));
			end
		endcase
	endfunction

	initial begin
		logic signed [31:0] reset_probe [11];
		reset_probe  = '{32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1,
			32'sd255, 32'sd256, 32'sd32768, 32'sd65279, 32'sd65280, 32'sd65281,
			32'sh7FFF_FFFF};
		sb           = new();
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		pixel_ready  = 1'b0;
		wr_en        = 1'b0;
		wr_idx       = stcp_pkg::CFG_SCALE_LOW;
		wr_data      = '0;
		steady       = 1'b0;
		stall_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: default scale, green tint. Below, on and past both bounds.
		foreach (reset_probe[i])
			send_sample(reset_probe[i]);

		// Reversed bounds in grey: 0 at or below scale_low, 255 above it.
		apply_setup('{32'sd1000, -32'sd1000, stcp_pkg::MAP_GREY, 8'd0, 8'd0, 8'd0,
			8'd96, 8'd96});
		send_sample(32'sd999);
		send_sample(32'sd1000);
		send_sample(32'sd1001);
		send_sample(32'sh8000_0000);

		// Equal bounds in jet, one sample either side of the split.
		apply_setup('{-32'sd5, -32'sd5, stcp_pkg::MAP_JET, 8'd0, 8'd0, 8'd0, 8'd96, 8'd96});
		send_sample(-32'sd5);
		send_sample(-32'sd4);

		// Hot map with an empty red ramp; level L comes from sample L * 256 here.
		apply_setup('{stcp_pkg::RST_SCALE_LOW, stcp_pkg::RST_SCALE_HIGH, stcp_pkg::MAP_HOT,
			8'd255, 8'd255, 8'd255, 8'd0, 8'd128});
		send_sample(32'sd0);
		send_sample(32'sd127 * 256);
		send_sample(32'sd128 * 256);
		send_sample(32'sd65280);

		// Hot spans summing past 255: blue is never reached.
		apply_setup('{stcp_pkg::RST_SCALE_LOW, stcp_pkg::RST_SCALE_HIGH, stcp_pkg::MAP_HOT,
			8'd0, 8'd0, 8'd0, 8'd200, 8'd100});
		send_sample(32'sd199 * 256);
		send_sample(32'sd200 * 256);
		send_sample(32'sd65280);

		// Random phases: fresh registers each time, a stretch in the middle with no idling.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			apply_setup(random_setup());
			steady <= (phase >= 6 && phase <= 8);
			repeat (ITEMS_PER_PHASE)
				send_sample(random_sample(sb.setup));
		end

		steady <= 1'b0;
		wait_for_idle();
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
src/stcp_pkg.sv
src/stcp_div.sv
src/sample_to_colour_pixel.sv
src/stcp_checker.sv
bench/sample_to_colour_pixel_tb.sv
